>>> sv/rrpc_pkg.sv
// Package for the range-rule packet classifier: action codes, rule and
// tuple word indexes, field positions and the controller command struct.
// No dependencies.
package rrpc_pkg;

  localparam logic [1:0] ACT_WR_RULE  = 2'd0;
  localparam logic [1:0] ACT_INVAL    = 2'd1;
  localparam logic [1:0] ACT_WR_TUPLE = 2'd2;
  localparam logic [1:0] ACT_CLASSIFY = 2'd3;

  localparam int RULE_WORDS  = 12;
  localparam int TUPLE_WORDS = 7;
  localparam int WSEL_W      = 4;
  localparam int DROP_BIT    = 32;
  localparam int LOG_BIT     = 33;
  localparam logic [7:0] IPV4_VERSION = 8'd4;

  localparam logic [3:0] RW_CTRL   = 4'd0;
  localparam logic [3:0] RW_PORTS  = 4'd1;
  localparam logic [3:0] RW_SRC_SL = 4'd2;
  localparam logic [3:0] RW_SRC_SH = 4'd3;
  localparam logic [3:0] RW_SRC_EL = 4'd4;
  localparam logic [3:0] RW_SRC_EH = 4'd5;
  localparam logic [3:0] RW_DST_SL = 4'd6;
  localparam logic [3:0] RW_DST_SH = 4'd7;
  localparam logic [3:0] RW_DST_EL = 4'd8;
  localparam logic [3:0] RW_DST_EH = 4'd9;
  localparam logic [3:0] RW_NAME_L = 4'd10;
  localparam logic [3:0] RW_NAME_H = 4'd11;

  typedef struct packed {
    logic wr_rule;      // store word into rule RAM and set valid
    logic inval;        // clear valid bit of slot
    logic wr_tuple;     // store tuple word
    logic scan_start;   // clear scan state, begin walk at slot 0
    logic rd_en;        // issue a rule word read
    logic eval;         // read data for current word is presented
    logic rule_done;    // last word of a rule was evaluated this cycle
  } rrpc_cmd_t;

  typedef struct packed {
    logic hit;          // latched match of the last finished rule
    logic slot_valid;   // current scan slot has valid bit set
  } rrpc_sts_t;

  // name equal up to and including first zero byte over nbytes of 16
  function automatic logic name_ok(input logic [127:0] tn, input logic [127:0] rn,
                                   input int nbytes);
    logic stop;
    logic ok;
    stop = 1'b0;
    ok   = 1'b1;
    if (tn[7:0] == 8'd0) begin
      ok = (rn[7:0] == 8'd0);
    end else if (rn[7:0] == 8'd0) begin
      ok = 1'b0;
    end else begin
      for (int i = 0; i < 16; i++) begin
        if (i < nbytes && !stop) begin
          if (tn[8*i +: 8] != rn[8*i +: 8]) begin
            ok   = 1'b0;
            stop = 1'b1;
          end else if (tn[8*i +: 8] == 8'd0) begin
            stop = 1'b1;
          end
        end
      end
    end
    return ok;
  endfunction

endpackage

>>> sv/rrpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module rrpc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/rrpc_ctrl.sv
// Controller for the classifier: decodes beats, sequences the rule scan
// (one rule word per cycle, pausing while each rule resolves) and owns
// the input and output handshakes. Depends on rrpc_pkg.
module rrpc_ctrl #(
  parameter int RULES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic [1:0]         in_action,
  input  logic               slot_in_range,
  input  logic               wsel_rule_ok,
  input  logic               wsel_tuple_ok,
  input  logic               out_tready,
  input  rrpc_pkg::rrpc_sts_t sts,
  output logic               in_tready,
  output logic               out_tvalid,
  output logic               scan_last,
  output logic [$clog2(RULES+1)-1:0] slot_cnt,
  output logic [3:0]         word_cnt,
  output rrpc_pkg::rrpc_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;
  localparam int SC_W = $clog2(RULES+1);

  logic [1:0]      state_r, state_nxt;
  logic [SC_W-1:0] slot_r, slot_nxt;
  logic [3:0]      word_r, word_nxt;
  logic            pend_r, pend_nxt;  // read issued last cycle
  logic [3:0]      pword_r, pword_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign slot_cnt   = slot_r;
  assign word_cnt   = pword_r;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    word_nxt  = word_r;
    pend_nxt  = 1'b0;
    pword_nxt = pword_r;
    cmd       = '0;
    scan_last = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_action)
            rrpc_pkg::ACT_WR_RULE:  cmd.wr_rule  = slot_in_range && wsel_rule_ok;
            rrpc_pkg::ACT_INVAL:    cmd.inval    = slot_in_range;
            rrpc_pkg::ACT_WR_TUPLE: cmd.wr_tuple = wsel_tuple_ok;
            rrpc_pkg::ACT_CLASSIFY: begin
              cmd.scan_start = 1'b1;
              state_nxt = ST_SCAN;
              slot_nxt  = '0;
              word_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (pend_r) begin
          cmd.eval = 1'b1;
          if (pword_r == 4'(rrpc_pkg::RULE_WORDS - 1)) begin
            cmd.rule_done = 1'b1;
          end
        end
        if (pend_r && pword_r == 4'(rrpc_pkg::RULE_WORDS - 1)) begin
          // rule fully evaluated; hit is visible next cycle, so stop issuing
          slot_nxt = slot_r + SC_W'(1);
          word_nxt = '0;
        end else if (sts.hit) begin
          state_nxt = ST_OUT;
        end else if (slot_r == SC_W'(RULES)) begin
          scan_last = 1'b1;
          state_nxt = ST_OUT;
        end else if (!sts.slot_valid) begin
          slot_nxt = slot_r + SC_W'(1);
        end else if (!pend_r || word_r != '0) begin
          cmd.rd_en = 1'b1;
          pend_nxt  = 1'b1;
          pword_nxt = word_r;
          word_nxt  = (word_r == 4'(rrpc_pkg::RULE_WORDS - 1)) ? word_r : word_r + 4'd1;
          if (word_r == 4'(rrpc_pkg::RULE_WORDS - 1)) begin
            word_nxt = 4'd0;
          end
        end
        if (cmd.rd_en && word_r == 4'(rrpc_pkg::RULE_WORDS - 1)) begin
          word_nxt = 4'd15; // hold off issue until rule resolves
        end
        if (!cmd.rd_en && word_r == 4'd15 && !(pend_r &&
            pword_r == 4'(rrpc_pkg::RULE_WORDS - 1))) begin
          word_nxt = 4'd15;
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
      word_r  <= '0;
      pend_r  <= 1'b0;
      pword_r <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      word_r  <= word_nxt;
      pend_r  <= pend_nxt;
      pword_r <= pword_nxt;
    end
  end

endmodule

>>> sv/rrpc_dp.sv
// Datapath for the classifier: rule RAM, valid bits, tuple registers and
// the per-word match accumulator. Depends on rrpc_pkg and rrpc_ram.
module rrpc_dp #(
  parameter int RULES      = 64,
  parameter int NAME_BYTES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rrpc_pkg::rrpc_cmd_t cmd,
  input  logic [$clog2(RULES+1)-1:0] slot_cnt,
  input  logic [3:0]         word_cnt,
  input  logic [3:0]         rd_word,
  input  logic               scan_last,
  input  logic [5:0]         in_slot,
  input  logic [3:0]         in_wsel,
  input  logic [63:0]        in_value,
  output logic               slot_in_range,
  output logic               wsel_rule_ok,
  output logic               wsel_tuple_ok,
  output rrpc_pkg::rrpc_sts_t sts,
  output logic               res_matched,
  output logic [5:0]         res_slot,
  output logic               res_drop,
  output logic               res_log
);

  localparam int SL_W  = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int SC_W  = $clog2(RULES+1);
  localparam int DEPTH = RULES * rrpc_pkg::RULE_WORDS;
  localparam int AD_W  = $clog2(DEPTH);

  logic [RULES-1:0] valid_r;
  logic [63:0]      tup_r [rrpc_pkg::TUPLE_WORDS];
  logic [63:0]      rd;
  logic [AD_W-1:0]  waddr, raddr;
  logic [SL_W-1:0]  wslot, sslot;

  logic             ok_r, ok_nxt, hit_r, hit_nxt, v4_r, v4_nxt;
  logic             drop_r, log_r;
  logic [63:0]      prev_r;
  logic [SL_W-1:0]  hslot_r;
  logic             ok_w;

  assign slot_in_range = (7'(in_slot) < 7'(RULES)) || (RULES >= 64);
  assign wsel_rule_ok  = in_wsel < 4'(rrpc_pkg::RULE_WORDS);
  assign wsel_tuple_ok = in_wsel < 4'(rrpc_pkg::TUPLE_WORDS);
  assign wslot = SL_W'(in_slot);
  assign sslot = SL_W'(slot_cnt);
  assign waddr = AD_W'(wslot) * AD_W'(rrpc_pkg::RULE_WORDS) + AD_W'(in_wsel);
  assign raddr = AD_W'(sslot) * AD_W'(rrpc_pkg::RULE_WORDS) + AD_W'(rd_word);

  rrpc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.wr_rule),
    .waddr (waddr),
    .wdata (in_value),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rd)
  );

  assign sts.slot_valid = (slot_cnt < SC_W'(RULES)) && valid_r[sslot];
  assign sts.hit        = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.wr_rule) begin
      valid_r[wslot] <= 1'b1;
    end else if (cmd.inval) begin
      valid_r[wslot] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rrpc_pkg::TUPLE_WORDS; i++) tup_r[i] <= '0;
    end else if (cmd.wr_tuple) begin
      tup_r[3'(in_wsel)] <= in_value;
    end
  end

  // per-word checks; pairs use the previous word held in prev_r
  always_comb begin
    logic [63:0] t0;
    logic [15:0] sp, dp;
    t0  = tup_r[0];
    sp  = t0[47:32];
    dp  = t0[63:48];
    ok_w = 1'b1;
    unique case (word_cnt)
      rrpc_pkg::RW_CTRL: begin
        ok_w = (rd[7:0] == t0[7:0]) && (rd[15:8] == t0[15:8]) &&
               ((rd[23:16] & t0[23:16]) != 8'd0);
      end
      rrpc_pkg::RW_PORTS: begin
        ok_w = (rd[15:0] == 16'd0 || (rd[15:0] <= sp && sp <= rd[31:16])) &&
               (rd[47:32] == 16'd0 || (rd[47:32] <= dp && dp <= rd[63:48]));
      end
      rrpc_pkg::RW_NAME_H: begin
        ok_w = rrpc_pkg::name_ok({tup_r[6], tup_r[5]}, {rd, prev_r}, NAME_BYTES);
      end
      default: ok_w = 1'b1;
    endcase
  end

  logic [127:0] start_r;
  logic         addr_ok;
  always_comb begin
    logic [127:0] en, ad;
    logic [31:0]  a4;
    logic         is_src;
    is_src = (word_cnt == rrpc_pkg::RW_SRC_EH);
    en = {rd, prev_r};
    ad = is_src ? {tup_r[2], tup_r[1]} : {tup_r[4], tup_r[3]};
    a4 = ad[31:0];
    if (v4_r) begin
      addr_ok = (start_r[31:0] == 32'd0) ||
                (start_r[31:0] <= a4 && a4 <= en[31:0]);
    end else begin
      addr_ok = (start_r == 128'd0) || (start_r <= ad && ad <= en);
    end
  end

  always_comb begin
    ok_nxt  = ok_r;
    hit_nxt = hit_r;
    v4_nxt  = v4_r;
    if (cmd.scan_start) begin
      hit_nxt = 1'b0;
      ok_nxt  = 1'b1;
    end else if (cmd.eval) begin
      if (word_cnt == rrpc_pkg::RW_CTRL) begin
        ok_nxt = ok_w;
        v4_nxt = (rd[7:0] == rrpc_pkg::IPV4_VERSION);
      end else if (word_cnt == rrpc_pkg::RW_SRC_EH || word_cnt == rrpc_pkg::RW_DST_EH) begin
        ok_nxt = ok_r && addr_ok;
      end else begin
        ok_nxt = ok_r && ok_w;
      end
      if (cmd.rule_done) begin
        hit_nxt = ok_nxt;
        ok_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r  <= 1'b1;
      hit_r <= 1'b0;
      v4_r  <= 1'b0;
    end else begin
      ok_r  <= ok_nxt;
      hit_r <= hit_nxt;
      v4_r  <= v4_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      prev_r <= rd;
      if (word_cnt == rrpc_pkg::RW_CTRL) begin
        drop_r  <= rd[rrpc_pkg::DROP_BIT];
        log_r   <= rd[rrpc_pkg::LOG_BIT];
        hslot_r <= sslot;
      end
      if (word_cnt == rrpc_pkg::RW_SRC_SH || word_cnt == rrpc_pkg::RW_DST_SH) begin
        start_r <= {rd, prev_r};
      end
    end
  end

  assign res_matched = hit_r && !scan_last;
  assign res_slot    = res_matched ? 6'(hslot_r) : 6'd0;
  assign res_drop    = res_matched && drop_r;
  assign res_log     = res_matched && log_r;

endmodule

>>> sv/range_rule_packet_classifier.sv
// Top level of the range-rule packet classifier: stream ports, controller
// and datapath. Depends on rrpc_pkg, rrpc_ctrl, rrpc_dp.
//
//  channel | dir | fields
//  in_     | in  | tdata: action[1:0] rule_slot[7:2] word_select[11:8] word_value[75:12]
//  out_    | out | tdata: matched[0] matched_slot[6:1] drop[7] log[8]
//
// Classify walks slots 0..RULES-1 and stops at the first hit; an invalid
// slot is skipped, a valid one has its twelve rule words read from the RAM
// and its match resolved before the next slot. The result is held on
// out_tdata until taken; no input is accepted meanwhile. Synchronous
// reset clears valid bits and tuple words.
module range_rule_packet_classifier #(
  parameter int RULES      = 64,
  parameter int NAME_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // action, rule_slot, word_select, word_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // matched, matched_slot, drop, log
);

  localparam int SC_W = $clog2(RULES+1);

  rrpc_pkg::rrpc_cmd_t cmd;
  rrpc_pkg::rrpc_sts_t sts;
  logic [SC_W-1:0] slot_cnt;
  logic [3:0]      word_cnt;
  logic            slot_in_range, wsel_rule_ok, wsel_tuple_ok, scan_last;
  logic            in_fire;
  logic            m, d, l;
  logic [5:0]      ms;
  logic [3:0]      rd_word;

  assign in_fire = in_tvalid && in_tready;

  rrpc_ctrl #(.RULES(RULES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_action(in_tdata[1:0]),
    .slot_in_range(slot_in_range), .wsel_rule_ok(wsel_rule_ok),
    .wsel_tuple_ok(wsel_tuple_ok), .out_tready(out_tready), .sts(sts),
    .in_tready(in_tready), .out_tvalid(out_tvalid), .scan_last(scan_last),
    .slot_cnt(slot_cnt), .word_cnt(word_cnt), .cmd(cmd)
  );

  // read address word: ctrl's issue counter is internal, mirror it here
  logic [3:0] iss_r, iss_nxt;
  always_comb begin
    iss_nxt = iss_r;
    if (cmd.scan_start) iss_nxt = 4'd0;
    else if (cmd.rd_en) iss_nxt = (iss_r == 4'(rrpc_pkg::RULE_WORDS - 1)) ? 4'd0
                                                                           : iss_r + 4'd1;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) iss_r <= '0;
    else        iss_r <= iss_nxt;
  end
  assign rd_word = iss_r;

  rrpc_dp #(.RULES(RULES), .NAME_BYTES(NAME_BYTES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .slot_cnt(slot_cnt), .word_cnt(word_cnt),
    .rd_word(rd_word), .scan_last(scan_last),
    .in_slot(in_tdata[7:2]), .in_wsel(in_tdata[11:8]), .in_value(in_tdata[75:12]),
    .slot_in_range(slot_in_range), .wsel_rule_ok(wsel_rule_ok),
    .wsel_tuple_ok(wsel_tuple_ok), .sts(sts),
    .res_matched(m), .res_slot(ms), .res_drop(d), .res_log(l)
  );

  // result captured on leaving the scan
  logic [8:0] res_r;
  logic       out_was_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_was_r <= 1'b0;
    else        out_was_r <= out_tvalid;
    if (out_tvalid && !out_was_r) res_r <= {l, d, ms, m};
  end
  assign out_tdata = {7'd0, (out_tvalid && !out_was_r) ? {l, d, ms, m} : res_r};

  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input ready during result");
  a_drop_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[0] || (!out_tdata[7] && !out_tdata[8])))
    else $error("drop or log without match");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata[8:0]))
    else $error("result changed while stalled");

endmodule
